/* hw/rtl/efbr_pkg.sv */
// efbr_pkg: shared types and constants for the epoch frequency buffer.
// Used by efbr_ctrl, efbr_dp and the top level.
package efbr_pkg;

	localparam logic [1:0] FUNC_READ  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_TICK  = 2'd2;
	localparam logic [1:0] FUNC_PROBE = 2'd3;

	localparam logic [1:0] REG_LIMIT_ADDR = 2'd0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RD_INC,
		ST_EVICT,
		ST_SHIFT,
		ST_APPEND,
		ST_TICK,
		ST_DONE
	} efbr_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic clr_idx;
		logic step;
		logic scan_rd;
		logic inc_hit;
		logic evict_rd;
		logic shift_rd;
		logic append;
		logic tick_rd;
		logic take_best;
		logic drop;
		logic set_hit;
		logic finish;
	} efbr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] func;
		logic       idx_end;
		logic       match;
		logic       need_evict;
		logic       room;
	} efbr_sts_t;

endpackage

/* hw/rtl/efbr_dp.sv */
// efbr_dp: entry memory, scan index, best-weight tracker and result register.
// Depends on efbr_pkg.
module efbr_dp import efbr_pkg::*; #(
	parameter int MaxBlocks = 64,
	parameter int IdxW = 6,
	parameter int CntW = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  efbr_cmd_t        cmd,
	output efbr_sts_t        sts,
	input  logic [1:0]       in_func,
	input  logic [15:0]      in_file,
	input  logic [15:0]      in_seg,
	input  logic [CntW-1:0]  lim,
	output logic [33:0]      res
);
	logic [63:0] mem_q [MaxBlocks];
	logic [63:0] rd_q;
	logic        rd_vld_q;
	logic        sh_vld_q, tk_vld_q;
	logic [IdxW-1:0] wa_q;
	logic        we;
	logic [IdxW-1:0] wa;
	logic [63:0] wd;
	logic [15:0] cur_inc;
	logic [1:0]  func_q;
	logic [15:0] file_q, seg_q;
	logic [CntW-1:0] count_q, idx_q;
	logic [IdxW-1:0] best_q;
	logic [16:0] best_w_q;
	logic [63:0] best_e_q;
	logic        hit_q, ev_q;
	logic [33:0] res_q;
	logic [16:0] w;
	logic        first_q;

	// entry: {prev, cur, seg, file}
	assign w = {1'b0, rd_q[63:48]} + {1'b0, rd_q[47:32]};
	assign cur_inc = (rd_q[47:32] == 16'hFFFF) ? rd_q[47:32] : rd_q[47:32] + 16'd1;

	// single write port; shift and tick write back the entry that their previous read left in rd_q
	always_comb begin
		we = 1'b1;
		wa = wa_q;
		wd = rd_q;
		if (cmd.inc_hit) begin
			wa = best_q;
			wd = {rd_q[63:48], cur_inc, rd_q[31:0]};
		end else if (cmd.append) begin
			wa = count_q[IdxW-1:0];
			wd = {32'd0, seg_q, file_q};
		end else if (tk_vld_q) begin
			wd = {rd_q[47:32], 16'd0, rd_q[31:0]};
		end else if (!sh_vld_q) begin
			we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_rd || cmd.evict_rd || cmd.shift_rd || cmd.tick_rd)
			rd_q <= mem_q[idx_q[IdxW-1:0]];
		if (we)
			mem_q[wa] <= wd;
		if (cmd.load) begin
			func_q <= in_func;
			file_q <= in_file;
			seg_q  <= in_seg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0; idx_q <= '0; best_q <= '0; best_w_q <= '0;
			hit_q <= 1'b0; ev_q <= 1'b0; res_q <= '0; rd_vld_q <= 1'b0;
			first_q <= 1'b1; best_e_q <= '0;
			sh_vld_q <= 1'b0; tk_vld_q <= 1'b0; wa_q <= '0;
		end else begin
			rd_vld_q <= cmd.evict_rd;
			sh_vld_q <= cmd.shift_rd;
			tk_vld_q <= cmd.tick_rd;
			if (cmd.shift_rd) wa_q <= idx_q[IdxW-1:0] - IdxW'(1);
			else if (cmd.tick_rd) wa_q <= idx_q[IdxW-1:0];
			if (cmd.load) begin
				hit_q <= 1'b0; ev_q <= 1'b0; first_q <= 1'b1;
				best_e_q <= '0;
			end
			if (cmd.clr_idx) idx_q <= '0;
			else if (cmd.step) idx_q <= idx_q + CntW'(1);
			if (cmd.set_hit) begin
				hit_q <= 1'b1;
				best_q <= idx_q[IdxW-1:0] - IdxW'(1);
			end
			if (rd_vld_q && (first_q || w > best_w_q)) begin
				best_w_q <= w;
				best_q   <= idx_q[IdxW-1:0] - IdxW'(1);
				best_e_q <= rd_q;
				first_q  <= 1'b0;
			end
			if (cmd.take_best) begin
				ev_q  <= 1'b1;
				idx_q <= CntW'(best_q) + CntW'(1);
			end
			if (cmd.drop) count_q <= count_q - CntW'(1);
			if (cmd.append) count_q <= count_q + CntW'(1);
			if (cmd.finish)
				res_q <= {best_e_q[31:16] & {16{ev_q}}, best_e_q[15:0] & {16{ev_q}},
					ev_q, hit_q};
		end
	end

	assign res = res_q;
	assign sts.func = func_q;
	assign sts.idx_end = (idx_q >= count_q);
	assign sts.match = (rd_q[15:0] == file_q) && (rd_q[31:16] == seg_q);
	assign sts.need_evict = (count_q >= lim) && (count_q != '0);
	assign sts.room = (count_q < CntW'(MaxBlocks));
endmodule

/* hw/rtl/efbr_ctrl.sv */
// efbr_ctrl: sequencer for read, probe, write/evict and epoch tick.
// Depends on efbr_pkg.
module efbr_ctrl import efbr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  efbr_sts_t sts,
	output efbr_cmd_t cmd
);
	efbr_state_t state_q, state_d;
	logic vld_q, vld_d, pend_q, pend_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; vld_q <= 1'b0; pend_q <= 1'b0;
		end else begin
			state_q <= state_d; vld_q <= vld_d; pend_q <= pend_d;
		end
	end

	// pend_q: a read beat from the scan is in rd_q awaiting compare
	always_comb begin
		state_d = state_q;
		cmd = '0;
		pend_d = 1'b0;
		vld_d = vld_q && !out_ready;
		in_ready = (state_q == ST_IDLE);
		out_valid = vld_q;
		unique case (state_q)
			ST_IDLE: if (in_valid && in_ready) begin
				cmd.load = 1'b1; cmd.clr_idx = 1'b1;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				priority if (sts.func == FUNC_WRITE) begin
					if (!sts.need_evict) state_d = ST_APPEND;
					else if (!sts.idx_end) begin
						cmd.evict_rd = 1'b1; cmd.step = 1'b1;
					end else state_d = ST_EVICT;
				end else if (sts.func == FUNC_TICK) begin
					state_d = ST_TICK;
				end else begin
					if (pend_q && sts.match) begin
						cmd.set_hit = 1'b1;
						state_d = (sts.func == FUNC_READ) ? ST_RD_INC : ST_DONE;
					end else if (!sts.idx_end) begin
						cmd.scan_rd = 1'b1; cmd.step = 1'b1; pend_d = 1'b1;
					end else state_d = ST_DONE;
				end
			end
			ST_RD_INC: begin
				cmd.inc_hit = 1'b1; state_d = ST_DONE;
			end
			ST_EVICT: begin
				cmd.take_best = 1'b1; state_d = ST_SHIFT;
			end
			ST_SHIFT: begin
				if (sts.idx_end) begin
					cmd.drop = 1'b1; state_d = ST_APPEND;
				end else begin
					cmd.shift_rd = 1'b1; cmd.step = 1'b1;
				end
			end
			ST_APPEND: begin
				cmd.append = sts.room; state_d = ST_DONE;
			end
			ST_TICK: begin
				if (sts.idx_end) state_d = ST_DONE;
				else begin
					cmd.tick_rd = 1'b1; cmd.step = 1'b1;
				end
			end
			ST_DONE: if (!vld_q || out_ready) begin
				cmd.finish = 1'b1; vld_d = 1'b1; state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid) else $error("result not raised");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready) else $error("accept while busy");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule

/* hw/rtl/epoch_frequency_buffer_replacement.sv */
// epoch_frequency_buffer_replacement: top level of the epoch frequency buffer.
// Depends on efbr_pkg, efbr_ctrl, efbr_dp.
//
// Usage:
//   s_axis beat: func, file_id, seg_id. m_axis beat: hit, evicted, evicted
//   file and segment. One result per request, one request at a time.
//   N is the occupancy, at most MAX_BLOCKS; the entry memory, with one read
//   and one write port, moves one entry per cycle. A read or probe scans
//   the entries until one matches; a write at the limit scans all N for
//   the highest weight, shifts the entries behind the evicted one down and
//   appends; an epoch tick rewrites all N. New requests are taken from the
//   cycle in which the result is raised.
//   The result is held in an output register until taken; with a stalled
//   receiver the next request runs up to its result and waits there.
//   Reset empties the table and sets block_limit to 64; the APB port
//   writes block_limit at address 0.
module epoch_frequency_buffer_replacement import efbr_pkg::*; #(
	parameter int MAX_BLOCKS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // func[1:0], file_id[17:2], seg_id[33:18], zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // hit, evicted, evicted_file_id, evicted_seg_id, zero
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int IdxW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CntW = $clog2(MAX_BLOCKS + 1);

	logic [6:0] limit_q;
	logic [CntW-1:0] lim_eff;
	efbr_cmd_t cmd;
	efbr_sts_t sts;
	logic [33:0] res;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) limit_q <= 7'd64;
		else if (psel && penable && pwrite && paddr == REG_LIMIT_ADDR)
			limit_q <= pwdata[6:0];
	end
	assign prdata = {25'd0, limit_q};

	always_comb begin
		if (limit_q == 7'd0) lim_eff = CntW'(1);
		else if (32'(limit_q) > MAX_BLOCKS) lim_eff = CntW'(MAX_BLOCKS);
		else lim_eff = CntW'(limit_q);
	end

	efbr_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.sts, .cmd
	);

	efbr_dp #(.MaxBlocks(MAX_BLOCKS), .IdxW(IdxW), .CntW(CntW)) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.in_func(s_axis_tdata[1:0]), .in_file(s_axis_tdata[17:2]),
		.in_seg(s_axis_tdata[33:18]), .lim(lim_eff), .res
	);

	assign m_axis_tdata = {6'd0, res};
endmodule

/* sim/tb_epoch_frequency_buffer_replacement.sv */
// Testbench for epoch_frequency_buffer_replacement: random and directed requests
// checked against a behavioral table model in a small scoreboard class.
// Depends on efbr_pkg and the RTL of the block.
module tb_epoch_frequency_buffer_replacement;
	import efbr_pkg::*;

	// lowest bit last: hit at bit 0
	typedef struct packed {
		logic [15:0] ev_seg;
		logic [15:0] ev_file;
		logic        evicted;
		logic        hit;
	} resp_t;

	class buffer_scoreboard;
		logic [15:0] tab_file[64];
		logic [15:0] tab_seg[64];
		logic [15:0] cnt_cur[64];
		logic [15:0] cnt_prev[64];
		int          occupancy;
		logic [6:0]  limit_reg;
		resp_t       pending[$];
		int          errors;

		function new();
			occupancy = 0;
			limit_reg = 7'd64;
			errors = 0;
		endfunction

		function int find_block(logic [15:0] f, logic [15:0] s);
			for (int i = 0; i < occupancy; i++)
				if (tab_file[i] == f && tab_seg[i] == s) return i;
			return -1;
		endfunction

		function void note_request(logic [1:0] fn, logic [15:0] f, logic [15:0] s);
			resp_t r;
			int pos, lim, best;
			logic [16:0] w, best_w;
			r = '0;
			lim = (limit_reg < 1) ? 1 : ((limit_reg > 64) ? 64 : limit_reg);
			case (fn)
				FUNC_READ: begin
					pos = find_block(f, s);
					if (pos >= 0) begin
						if (cnt_cur[pos] != 16'hFFFF) cnt_cur[pos]++;
						r.hit = 1'b1;
					end
				end
				FUNC_WRITE: begin
					if (occupancy >= lim && occupancy > 0) begin
						best = 0;
						best_w = 0;
						for (int i = 0; i < occupancy; i++) begin
							w = {1'b0, cnt_prev[i]} + {1'b0, cnt_cur[i]};
							if (i == 0 || w > best_w) begin
								best_w = w;
								best = i;
							end
						end
						r.evicted = 1'b1;
						r.ev_file = tab_file[best];
						r.ev_seg = tab_seg[best];
						for (int i = best; i < occupancy - 1; i++) begin
							tab_file[i] = tab_file[i+1];
							tab_seg[i] = tab_seg[i+1];
							cnt_cur[i] = cnt_cur[i+1];
							cnt_prev[i] = cnt_prev[i+1];
						end
						occupancy--;
					end
					if (occupancy < 64) begin
						tab_file[occupancy] = f;
						tab_seg[occupancy] = s;
						cnt_cur[occupancy] = 0;
						cnt_prev[occupancy] = 0;
						occupancy++;
					end
				end
				FUNC_TICK: begin
					for (int i = 0; i < occupancy; i++) begin
						cnt_prev[i] = cnt_cur[i];
						cnt_cur[i] = 0;
					end
				end
				default: r.hit = (find_block(f, s) >= 0);
			endcase
			pending = {pending, r};
		endfunction

		function void report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endfunction

		function void check_result(logic [39:0] data);
			resp_t got, exp;
			got = data[33:0];
			if (pending.size() == 0) begin
				report($sformatf("unexpected result %h", data));
				return;
			end
			exp = pending.pop_front();
			if (got.hit !== exp.hit)
				report($sformatf("hit %b exp %b", got.hit, exp.hit));
			if (got.evicted !== exp.evicted)
				report($sformatf("evicted %b exp %b", got.evicted, exp.evicted));
			if (got.ev_file !== exp.ev_file)
				report($sformatf("ev file %h exp %h", got.ev_file, exp.ev_file));
			if (got.ev_seg !== exp.ev_seg)
				report($sformatf("ev seg %h exp %h", got.ev_seg, exp.ev_seg));
			if (data[39:34] !== '0) report("pad bits set");
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	buffer_scoreboard sb = new();
	bit quiet_tail = 1'b0;
	int cycles = 0;
	logic [15:0] recent_file[8];
	logic [15:0] recent_seg[8];

	always #1 clk = ~clk;

	epoch_frequency_buffer_replacement uut (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
	end

	initial begin : sink
		int gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 9);
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	task automatic apb_write(logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= REG_LIMIT_ADDR; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		sb.limit_reg = val[6:0];
	endtask

	// tvalid stays high between back-to-back beats; drain() drops it
	task automatic send_request(logic [1:0] fn, logic [15:0] f, logic [15:0] s);
		int gap;
		if (!quiet_tail && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 9);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, s, f, fn};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(fn, f, s);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic random_phase(int count);
		logic [1:0] fn;
		logic [15:0] f, s;
		int k, pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			k = $urandom_range(0, 7);
			fn = (pick < 40) ? FUNC_READ : (pick < 70) ? FUNC_WRITE :
				(pick < 78) ? FUNC_TICK : FUNC_PROBE;
			if ($urandom_range(0, 4) == 0) begin
				f = 16'($urandom); s = 16'($urandom);
			end else begin
				f = recent_file[k]; s = recent_seg[k];
			end
			if (fn == FUNC_WRITE && $urandom_range(0, 2) == 0) begin
				f = 16'($urandom); s = 16'($urandom);
				recent_file[k] = f; recent_seg[k] = s;
			end
			send_request(fn, f, s);
		end
	endtask

	initial begin
		for (int i = 0; i < 8; i++) begin
			recent_file[i] = 16'(i);
			recent_seg[i] = 16'hFFFF - 16'(i);
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		// directed: extremes, every function, empty-table cases
		send_request(FUNC_READ, 16'h0000, 16'h0000);
		send_request(FUNC_PROBE, 16'hFFFF, 16'hFFFF);
		send_request(FUNC_TICK, 16'h0000, 16'h0000);
		send_request(FUNC_WRITE, 16'hFFFF, 16'hFFFF);
		send_request(FUNC_WRITE, 16'h0000, 16'h0000);
		send_request(FUNC_WRITE, 16'hFFFF, 16'hFFFF);
		send_request(FUNC_READ, 16'hFFFF, 16'hFFFF);
		send_request(FUNC_READ, 16'h0000, 16'h0000);
		send_request(FUNC_PROBE, 16'h0000, 16'h0000);
		send_request(FUNC_TICK, 16'h1234, 16'h5678);
		send_request(FUNC_READ, 16'h0000, 16'h0000);
		drain();
		// limit zero acts as one, then lowered below occupancy
		apb_write(32'd0);
		send_request(FUNC_WRITE, 16'hA5A5, 16'h5A5A);
		send_request(FUNC_WRITE, 16'h5A5A, 16'hA5A5);
		drain();
		apb_write(32'd1);
		random_phase(100);
		drain();
		apb_write(32'd127);
		random_phase(60);
		drain();
		// repeated reads on a single entry, then a tick and an eviction
		apb_write(32'd2);
		send_request(FUNC_WRITE, 16'h7777, 16'h8888);
		send_request(FUNC_WRITE, 16'h9999, 16'h1111);
		repeat (20) send_request(FUNC_READ, 16'h9999, 16'h1111);
		send_request(FUNC_TICK, 16'h0, 16'h0);
		repeat (3) send_request(FUNC_READ, 16'h9999, 16'h1111);
		send_request(FUNC_WRITE, 16'h4321, 16'h1234);
		drain();
		apb_write(32'd4);
		random_phase(200);
		drain();
		apb_write(32'd64);
		random_phase(250);
		drain();
		apb_write(32'd8);
		random_phase(100);
		quiet_tail = 1'b1;
		random_phase(80);
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

/* sim.f */
hw/rtl/efbr_pkg.sv
hw/rtl/efbr_dp.sv
hw/rtl/efbr_ctrl.sv
hw/rtl/epoch_frequency_buffer_replacement.sv
sim/tb_epoch_frequency_buffer_replacement.sv
